// ----- sv/dhms_pkg.sv -----
// shared types, constants and width helpers for the dhms duration alu
// no dependencies; imported by every module of the block
package dhms_pkg;

  // default widths handed to the top level parameters
  localparam int DEF_DAY_BITS    = 16;
  localparam int DEF_FACTOR_BITS = 16;

  // field widths of one duration
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;

  // seconds within a day, and within an hour
  localparam int SUB_W  = 17;
  localparam int HSEC_W = 12;

  localparam logic [SUB_W-1:0]  SECS_PER_DAY  = 17'd86400;
  localparam logic [SUB_W-1:0]  SECS_PER_HOUR = 17'd3600;
  localparam logic [HSEC_W-1:0] SECS_PER_MIN  = 12'd60;

  localparam logic [HOUR_W-1:0] MAX_HOUR = 5'd23;
  localparam logic [MIN_W-1:0]  MAX_MIN  = 6'd59;
  localparam logic [SEC_W-1:0]  MAX_SEC  = 6'd59;

  // reciprocals for the hour and minute split, exact over their input ranges
  localparam int                  HOUR_RCP_W = 18;
  localparam logic [HOUR_RCP_W-1:0] HOUR_RCP = 18'd149131;
  localparam int                  HOUR_SHIFT = 29;
  localparam int                  MIN_RCP_W  = 13;
  localparam logic [MIN_RCP_W-1:0] MIN_RCP   = 13'd4370;
  localparam int                  MIN_SHIFT  = 18;

  // quotient bits retired by one divider stage
  localparam int DIG_W = 2;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_SUB   = 2'd1,
    FN_SCALE = 2'd2
  } func_e;

  // compare results and the forced-zero mark that travel with each beat
  typedef struct packed {
    logic less;
    logic equal;
    logic zero;
  } flags_t;

  // width of whole days before normalisation
  function automatic int base_w(int day_bits, int factor_bits);
    return day_bits + factor_bits;
  endfunction

  // width of the sub-day seconds dividend, rounded up to whole digits
  function automatic int dvd_w(int factor_bits);
    return ((SUB_W + factor_bits - 1 + DIG_W - 1) / DIG_W) * DIG_W;
  endfunction

endpackage

// ----- sv/dhms_prep.sv -----
// operand preparation: sub-day seconds, compare flags, day product, then
// per-operation base days and sub-day dividend; depends on dhms_pkg
module dhms_prep #(
  parameter int DAY_BITS    = dhms_pkg::DEF_DAY_BITS,
  parameter int FACTOR_BITS = dhms_pkg::DEF_FACTOR_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         vld_i,
  output logic                                         rdy_o,
  input  logic [1:0]                                   func_i,
  input  logic [DAY_BITS-1:0]                          a_days_i,
  input  logic [dhms_pkg::HOUR_W-1:0]                  a_hours_i,
  input  logic [dhms_pkg::MIN_W-1:0]                   a_minutes_i,
  input  logic [dhms_pkg::SEC_W-1:0]                   a_seconds_i,
  input  logic [DAY_BITS-1:0]                          b_days_i,
  input  logic [dhms_pkg::HOUR_W-1:0]                  b_hours_i,
  input  logic [dhms_pkg::MIN_W-1:0]                   b_minutes_i,
  input  logic [dhms_pkg::SEC_W-1:0]                   b_seconds_i,
  input  logic [FACTOR_BITS-1:0]                       factor_i,
  output logic                                         vld_o,
  input  logic                                         rdy_i,
  output logic [dhms_pkg::base_w(DAY_BITS, FACTOR_BITS)-1:0] base_o,
  output logic [dhms_pkg::dvd_w(FACTOR_BITS)-1:0]      dvd_o,
  output dhms_pkg::flags_t                             flags_o
);
  import dhms_pkg::*;

  localparam int BASE_W = base_w(DAY_BITS, FACTOR_BITS);
  localparam int DVD_W  = dvd_w(FACTOR_BITS);
  localparam int MAG_W  = FACTOR_BITS - 1;
  localparam int DD_W   = DAY_BITS + 2;
  localparam int DS_W   = SUB_W + 2;

  // stage enables, bubbles collapse
  logic s1_en, s2_en;
  logic s1_v_q, s2_v_q;

  // stage 1 registers
  func_e              func_q;
  logic [DAY_BITS-1:0] ad_q, bd_q;
  logic [SUB_W-1:0]   asub_q, bsub_q;
  logic [MAG_W-1:0]   fmag_q;
  logic               sczero_q, less_q, equal_q;
  logic [BASE_W-1:0]  bmul_q;

  logic [SUB_W-1:0]   asub_d, bsub_d;
  logic [MAG_W-1:0]   fmag_d;
  logic               sczero_d, less_d, equal_d;
  logic [BASE_W-1:0]  bmul_d;

  // stage 2 registers
  logic [BASE_W-1:0]  base_q, base_d;
  logic [DVD_W-1:0]   dvd_q, dvd_d;
  flags_t             flags_q, flags_d;

  // subtract path
  logic [DD_W-1:0]    dd, dn;
  logic [DS_W-1:0]    ds, sn, t1, t2, t_hi, day_s;
  logic               pos;

  assign s2_en = !s2_v_q || rdy_i;
  assign s1_en = !s1_v_q || s2_en;
  assign rdy_o = s1_en;

  // sub-day seconds, lexicographic compare, day product
  always_comb begin
    asub_d = SUB_W'(a_hours_i) * SECS_PER_HOUR
           + SUB_W'(a_minutes_i) * SUB_W'(SECS_PER_MIN)
           + SUB_W'(a_seconds_i);
    bsub_d = SUB_W'(b_hours_i) * SECS_PER_HOUR
           + SUB_W'(b_minutes_i) * SUB_W'(SECS_PER_MIN)
           + SUB_W'(b_seconds_i);
    less_d  = {a_days_i, a_hours_i, a_minutes_i, a_seconds_i}
            < {b_days_i, b_hours_i, b_minutes_i, b_seconds_i};
    equal_d = {a_days_i, a_hours_i, a_minutes_i, a_seconds_i}
           == {b_days_i, b_hours_i, b_minutes_i, b_seconds_i};
    fmag_d   = factor_i[MAG_W-1:0];
    sczero_d = factor_i[FACTOR_BITS-1] || (fmag_d == '0);
    bmul_d   = BASE_W'(a_days_i) * BASE_W'(fmag_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= vld_i;
      if (s2_en) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      func_q   <= func_e'(func_i);
      ad_q     <= a_days_i;
      bd_q     <= b_days_i;
      asub_q   <= asub_d;
      bsub_q   <= bsub_d;
      fmag_q   <= fmag_d;
      sczero_q <= sczero_d;
      less_q   <= less_d;
      equal_q  <= equal_d;
      bmul_q   <= bmul_d;
    end
  end

  // floored difference: day difference plus sub-day difference brought
  // into one day, then positivity check
  always_comb begin
    day_s = DS_W'(SECS_PER_DAY);
    dd    = DD_W'(ad_q) - DD_W'(bd_q);
    ds    = DS_W'(asub_q) - DS_W'(bsub_q);
    t1    = ds + day_s;
    t2    = t1 + day_s;
    t_hi  = ds - day_s;
    if (t1[DS_W-1]) begin
      sn = t2;
      dn = dd - DD_W'(2);
    end else if (ds[DS_W-1]) begin
      sn = t1;
      dn = dd - DD_W'(1);
    end else if (!t_hi[DS_W-1]) begin
      sn = t_hi;
      dn = dd + DD_W'(1);
    end else begin
      sn = ds;
      dn = dd;
    end
    pos = !dn[DD_W-1] && ((dn != '0) || (sn != '0));
  end

  // per-operation base days and sub-day dividend; a positive difference
  // can reach one day past the day range, kept so it saturates later
  always_comb begin
    flags_d.less  = less_q;
    flags_d.equal = equal_q;
    case (func_q)
      FN_ADD: begin
        base_d       = BASE_W'(ad_q) + BASE_W'(bd_q);
        dvd_d        = DVD_W'(asub_q) + DVD_W'(bsub_q);
        flags_d.zero = 1'b0;
      end
      FN_SUB: begin
        base_d       = BASE_W'(dn[DAY_BITS:0]);
        dvd_d        = DVD_W'(sn[SUB_W-1:0]);
        flags_d.zero = !pos;
      end
      FN_SCALE: begin
        base_d       = bmul_q;
        dvd_d        = DVD_W'(asub_q) * DVD_W'(fmag_q);
        flags_d.zero = sczero_q;
      end
      default: begin
        base_d       = '0;
        dvd_d        = '0;
        flags_d.zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      base_q  <= base_d;
      dvd_q   <= dvd_d;
      flags_q <= flags_d;
    end
  end

  assign vld_o   = s2_v_q;
  assign base_o  = base_q;
  assign dvd_o   = dvd_q;
  assign flags_o = flags_q;

endmodule

// ----- sv/dhms_div.sv -----
// pipelined long division of the sub-day dividend by seconds per day,
// two quotient bits per stage; depends on dhms_pkg
module dhms_div #(
  parameter int DAY_BITS    = dhms_pkg::DEF_DAY_BITS,
  parameter int FACTOR_BITS = dhms_pkg::DEF_FACTOR_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         vld_i,
  output logic                                         rdy_o,
  input  logic [dhms_pkg::base_w(DAY_BITS, FACTOR_BITS)-1:0] base_i,
  input  logic [dhms_pkg::dvd_w(FACTOR_BITS)-1:0]      dvd_i,
  input  dhms_pkg::flags_t                             flags_i,
  output logic                                         vld_o,
  input  logic                                         rdy_i,
  output logic [dhms_pkg::base_w(DAY_BITS, FACTOR_BITS)-1:0] base_o,
  output logic [dhms_pkg::dvd_w(FACTOR_BITS)-1:0]      quo_o,
  output logic [dhms_pkg::SUB_W-1:0]                   rem_o,
  output dhms_pkg::flags_t                             flags_o
);
  import dhms_pkg::*;

  localparam int BASE_W = base_w(DAY_BITS, FACTOR_BITS);
  localparam int DVD_W  = dvd_w(FACTOR_BITS);
  localparam int NDIG   = DVD_W / DIG_W;
  localparam int XW     = SUB_W + DIG_W;

  logic [NDIG-1:0]    en;
  logic               v_q     [NDIG];
  logic [SUB_W-1:0]   rem_q   [NDIG];
  logic [DVD_W-1:0]   dvd_q   [NDIG];
  logic [BASE_W-1:0]  base_q  [NDIG];
  flags_t             flags_q [NDIG];

  logic               src_v     [NDIG];
  logic [BASE_W-1:0]  src_base  [NDIG];
  flags_t             src_flags [NDIG];
  logic [SUB_W-1:0]   rem_d     [NDIG];
  logic [DVD_W-1:0]   dvd_d     [NDIG];

  // stage enables, last stage first
  always_comb begin
    en[NDIG-1] = !v_q[NDIG-1] || rdy_i;
    for (int g = NDIG - 2; g >= 0; g--) begin
      en[g] = !v_q[g] || en[g+1];
    end
  end

  assign rdy_o = en[0];

  // one restoring step per stage: bring down a digit, pick the quotient
  // digit from the multiples of a day, shift it in at the bottom
  always_comb begin
    logic [SUB_W-1:0]  s_rem;
    logic [DVD_W-1:0]  s_dvd;
    logic [XW-1:0]     x;
    logic [DIG_W-1:0]  qd;
    for (int g = 0; g < NDIG; g++) begin
      if (g == 0) begin
        src_v[g]     = vld_i;
        src_base[g]  = base_i;
        src_flags[g] = flags_i;
        s_rem        = '0;
        s_dvd        = dvd_i;
      end else begin
        src_v[g]     = v_q[g-1];
        src_base[g]  = base_q[g-1];
        src_flags[g] = flags_q[g-1];
        s_rem        = rem_q[g-1];
        s_dvd        = dvd_q[g-1];
      end
      x  = {s_rem, s_dvd[DVD_W-1 -: DIG_W]};
      qd = '0;
      for (int k = 1; k < (1 << DIG_W); k++) begin
        if (x >= XW'(k) * XW'(SECS_PER_DAY)) qd = DIG_W'(k);
      end
      rem_d[g] = SUB_W'(x - XW'(qd) * XW'(SECS_PER_DAY));
      dvd_d[g] = {s_dvd[DVD_W-DIG_W-1:0], qd};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NDIG; g++) v_q[g] <= 1'b0;
    end else begin
      for (int g = 0; g < NDIG; g++) begin
        if (en[g]) v_q[g] <= src_v[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NDIG; g++) begin
      if (en[g]) begin
        rem_q[g]   <= rem_d[g];
        dvd_q[g]   <= dvd_d[g];
        base_q[g]  <= src_base[g];
        flags_q[g] <= src_flags[g];
      end
    end
  end

  assign vld_o   = v_q[NDIG-1];
  assign base_o  = base_q[NDIG-1];
  assign quo_o   = dvd_q[NDIG-1];
  assign rem_o   = rem_q[NDIG-1];
  assign flags_o = flags_q[NDIG-1];

endmodule

// ----- sv/dhms_norm.sv -----
// normalisation: day total and saturation, split of the remaining seconds
// into hours, minutes and seconds, output register; depends on dhms_pkg
module dhms_norm #(
  parameter int DAY_BITS    = dhms_pkg::DEF_DAY_BITS,
  parameter int FACTOR_BITS = dhms_pkg::DEF_FACTOR_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         vld_i,
  output logic                                         rdy_o,
  input  logic [dhms_pkg::base_w(DAY_BITS, FACTOR_BITS)-1:0] base_i,
  input  logic [dhms_pkg::dvd_w(FACTOR_BITS)-1:0]      quo_i,
  input  logic [dhms_pkg::SUB_W-1:0]                   rem_i,
  input  dhms_pkg::flags_t                             flags_i,
  output logic                                         vld_o,
  input  logic                                         rdy_i,
  output logic [DAY_BITS-1:0]                          r_days_o,
  output logic [dhms_pkg::HOUR_W-1:0]                  r_hours_o,
  output logic [dhms_pkg::MIN_W-1:0]                   r_minutes_o,
  output logic [dhms_pkg::SEC_W-1:0]                   r_seconds_o,
  output logic                                         a_less_b_o,
  output logic                                         a_equal_b_o,
  output logic                                         overflow_o
);
  import dhms_pkg::*;

  localparam int BASE_W = base_w(DAY_BITS, FACTOR_BITS);
  localparam int DVD_W  = dvd_w(FACTOR_BITS);
  localparam int SM_W   = (BASE_W > DVD_W) ? BASE_W : DVD_W;
  localparam int HP_W   = SUB_W + HOUR_RCP_W;
  localparam int MP_W   = HSEC_W + MIN_RCP_W;

  logic a_en, b_en, c_en, d_en;
  logic a_v_q, b_v_q, c_v_q, d_v_q;

  // stage a
  logic [SM_W-1:0]     sum;
  logic [DAY_BITS-1:0] a_days_q, b_days_q, c_days_q;
  logic                a_ovf_q, b_ovf_q, c_ovf_q;
  flags_t              a_flags_q, b_flags_q, c_flags_q;
  logic [SUB_W-1:0]    a_rem_q;
  logic [HP_W-1:0]     a_hprod_q;

  // stage b
  logic [HOUR_W-1:0]   h_d, b_h_q, c_h_q;
  logic [HSEC_W-1:0]   r2_d, b_r2_q, c_r2_q;

  // stage c
  logic [MP_W-1:0]     c_mprod_q;

  // stage d
  logic [MIN_W-1:0]    m_d;
  logic [SEC_W-1:0]    s_d;
  logic [DAY_BITS-1:0] r_days_q;
  logic [HOUR_W-1:0]   r_hours_q;
  logic [MIN_W-1:0]    r_minutes_q;
  logic [SEC_W-1:0]    r_seconds_q;
  logic                less_q, equal_q, ovf_q;

  assign d_en  = !d_v_q || rdy_i;
  assign c_en  = !c_v_q || d_en;
  assign b_en  = !b_v_q || c_en;
  assign a_en  = !a_v_q || b_en;
  assign rdy_o = a_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (a_en) a_v_q <= vld_i;
      if (b_en) b_v_q <= a_v_q;
      if (c_en) c_v_q <= b_v_q;
      if (d_en) d_v_q <= c_v_q;
    end
  end

  // day total with overflow check, hour reciprocal product
  assign sum = SM_W'(base_i) + SM_W'(quo_i);

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_days_q  <= sum[DAY_BITS-1:0];
      a_ovf_q   <= |sum[SM_W-1:DAY_BITS];
      a_flags_q <= flags_i;
      a_rem_q   <= rem_i;
      a_hprod_q <= HP_W'(rem_i) * HP_W'(HOUR_RCP);
    end
  end

  // hours and seconds left within the hour
  assign h_d  = a_hprod_q[HOUR_SHIFT +: HOUR_W];
  assign r2_d = HSEC_W'(a_rem_q - SUB_W'(h_d) * SECS_PER_HOUR);

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      b_days_q  <= a_days_q;
      b_ovf_q   <= a_ovf_q;
      b_flags_q <= a_flags_q;
      b_h_q     <= h_d;
      b_r2_q    <= r2_d;
    end
  end

  // minute reciprocal product
  always_ff @(posedge clk_i) begin
    if (c_en) begin
      c_days_q  <= b_days_q;
      c_ovf_q   <= b_ovf_q;
      c_flags_q <= b_flags_q;
      c_h_q     <= b_h_q;
      c_r2_q    <= b_r2_q;
      c_mprod_q <= MP_W'(b_r2_q) * MP_W'(MIN_RCP);
    end
  end

  // minutes and seconds
  assign m_d = c_mprod_q[MIN_SHIFT +: MIN_W];
  assign s_d = SEC_W'(c_r2_q - HSEC_W'(m_d) * SECS_PER_MIN);

  // output register: forced zero, saturation or the normalised value
  always_ff @(posedge clk_i) begin
    if (d_en) begin
      less_q  <= c_flags_q.less;
      equal_q <= c_flags_q.equal;
      if (c_flags_q.zero) begin
        r_days_q    <= '0;
        r_hours_q   <= '0;
        r_minutes_q <= '0;
        r_seconds_q <= '0;
        ovf_q       <= 1'b0;
      end else if (c_ovf_q) begin
        r_days_q    <= '1;
        r_hours_q   <= MAX_HOUR;
        r_minutes_q <= MAX_MIN;
        r_seconds_q <= MAX_SEC;
        ovf_q       <= 1'b1;
      end else begin
        r_days_q    <= c_days_q;
        r_hours_q   <= c_h_q;
        r_minutes_q <= m_d;
        r_seconds_q <= s_d;
        ovf_q       <= 1'b0;
      end
    end
  end

  assign vld_o       = d_v_q;
  assign r_days_o    = r_days_q;
  assign r_hours_o   = r_hours_q;
  assign r_minutes_o = r_minutes_q;
  assign r_seconds_o = r_seconds_q;
  assign a_less_b_o  = less_q;
  assign a_equal_b_o = equal_q;
  assign overflow_o  = ovf_q;

endmodule

// ----- sv/dhms_duration_alu.sv -----
// top level of the days/hours/minutes/seconds duration alu
// depends on dhms_pkg, dhms_prep, dhms_div and dhms_norm
//
// channel | handshake                 | beat
// --------+---------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o   | func, operands a and b, signed factor
// out     | out_valid_o / out_stall_i | normalised result, compare flags, overflow
//
// one beat per cycle sustained while out is not stalled; the divider retires two
// quotient bits of the sub-day seconds per stage.
// reset clears only the stage valid bits; data registers are not reset.
// a stall on out holds the output register while earlier stages keep filling
// empty slots; in_stall_o rises only once every stage holds a beat.
module dhms_duration_alu #(
  parameter int DAY_BITS    = dhms_pkg::DEF_DAY_BITS,
  parameter int FACTOR_BITS = dhms_pkg::DEF_FACTOR_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [DAY_BITS-1:0]         a_days_i,
  input  logic [dhms_pkg::HOUR_W-1:0] a_hours_i,
  input  logic [dhms_pkg::MIN_W-1:0]  a_minutes_i,
  input  logic [dhms_pkg::SEC_W-1:0]  a_seconds_i,
  input  logic [DAY_BITS-1:0]         b_days_i,
  input  logic [dhms_pkg::HOUR_W-1:0] b_hours_i,
  input  logic [dhms_pkg::MIN_W-1:0]  b_minutes_i,
  input  logic [dhms_pkg::SEC_W-1:0]  b_seconds_i,
  input  logic signed [FACTOR_BITS-1:0] factor_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [DAY_BITS-1:0]         r_days_o,
  output logic [dhms_pkg::HOUR_W-1:0] r_hours_o,
  output logic [dhms_pkg::MIN_W-1:0]  r_minutes_o,
  output logic [dhms_pkg::SEC_W-1:0]  r_seconds_o,
  output logic                        a_less_b_o,
  output logic                        a_equal_b_o,
  output logic                        overflow_o
);
  import dhms_pkg::*;

  localparam int BASE_W = base_w(DAY_BITS, FACTOR_BITS);
  localparam int DVD_W  = dvd_w(FACTOR_BITS);

  logic              prep_rdy, prep_vld;
  logic [BASE_W-1:0] prep_base;
  logic [DVD_W-1:0]  prep_dvd;
  flags_t            prep_flags;

  logic              div_rdy, div_vld;
  logic [BASE_W-1:0] div_base;
  logic [DVD_W-1:0]  div_quo;
  logic [SUB_W-1:0]  div_rem;
  flags_t            div_flags;

  logic              norm_rdy;

  assign in_stall_o = !prep_rdy;

  // operand preparation
  dhms_prep #(
    .DAY_BITS    (DAY_BITS),
    .FACTOR_BITS (FACTOR_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (in_valid_i),
    .rdy_o       (prep_rdy),
    .func_i      (func_i),
    .a_days_i    (a_days_i),
    .a_hours_i   (a_hours_i),
    .a_minutes_i (a_minutes_i),
    .a_seconds_i (a_seconds_i),
    .b_days_i    (b_days_i),
    .b_hours_i   (b_hours_i),
    .b_minutes_i (b_minutes_i),
    .b_seconds_i (b_seconds_i),
    .factor_i    (factor_i),
    .vld_o       (prep_vld),
    .rdy_i       (div_rdy),
    .base_o      (prep_base),
    .dvd_o       (prep_dvd),
    .flags_o     (prep_flags)
  );

  // division of sub-day seconds into days and remainder
  dhms_div #(
    .DAY_BITS    (DAY_BITS),
    .FACTOR_BITS (FACTOR_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (prep_vld),
    .rdy_o   (div_rdy),
    .base_i  (prep_base),
    .dvd_i   (prep_dvd),
    .flags_i (prep_flags),
    .vld_o   (div_vld),
    .rdy_i   (norm_rdy),
    .base_o  (div_base),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .flags_o (div_flags)
  );

  // normalisation and output register
  dhms_norm #(
    .DAY_BITS    (DAY_BITS),
    .FACTOR_BITS (FACTOR_BITS)
  ) u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (div_vld),
    .rdy_o       (norm_rdy),
    .base_i      (div_base),
    .quo_i       (div_quo),
    .rem_i       (div_rem),
    .flags_i     (div_flags),
    .vld_o       (out_valid_o),
    .rdy_i       (!out_stall_i),
    .r_days_o    (r_days_o),
    .r_hours_o   (r_hours_o),
    .r_minutes_o (r_minutes_o),
    .r_seconds_o (r_seconds_o),
    .a_less_b_o  (a_less_b_o),
    .a_equal_b_o (a_equal_b_o),
    .overflow_o  (overflow_o)
  );

endmodule

// ----- verif/tb_dhms_duration_alu.sv -----
`timescale 1ns / 1ps
// self-checking testbench for dhms_duration_alu: directed and random beats, with paced
// input bursts and a patterned output stall; depends on dhms_pkg and the alu rtl
module tb_dhms_duration_alu;
  import dhms_pkg::*;

  localparam int DAY_W      = DEF_DAY_BITS;
  localparam int FACT_W     = DEF_FACTOR_BITS;
  localparam int CLK_PERIOD = 4;
  localparam int RAND_BEATS = 600;
  localparam int DRAIN_CYC  = 40;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [DAY_W-1:0] DAY_MAX   = '1;
  localparam logic [1:0]       FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [DAY_W-1:0]  days;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } dur_t;

  typedef struct packed {
    logic [1:0]        func;
    dur_t              a;
    dur_t              b;
    logic [FACT_W-1:0] factor;
  } dur_op_t;

  typedef struct packed {
    dur_t r;
    logic less;
    logic equal;
    logic overflow;
  } dur_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] func_i;
  logic [DAY_W-1:0] a_days_i, b_days_i;
  logic [HOUR_W-1:0] a_hours_i, b_hours_i;
  logic [MIN_W-1:0] a_minutes_i, b_minutes_i;
  logic [SEC_W-1:0] a_seconds_i, b_seconds_i;
  logic signed [FACT_W-1:0] factor_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [DAY_W-1:0] r_days_o;
  logic [HOUR_W-1:0] r_hours_o;
  logic [MIN_W-1:0] r_minutes_o;
  logic [SEC_W-1:0] r_seconds_o;
  logic a_less_b_o, a_equal_b_o, overflow_o;

  dur_res_t expected_q[$];
  dur_res_t oldest_res;
  int       error_count = 0;
  int       cycle_count = 0;
  int       burst_left  = 0;
  logic [5:0] rx_tick = '0;
  int         rx_mode = 0;

  dhms_duration_alu uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .a_days_i    (a_days_i),
    .a_hours_i   (a_hours_i),
    .a_minutes_i (a_minutes_i),
    .a_seconds_i (a_seconds_i),
    .b_days_i    (b_days_i),
    .b_hours_i   (b_hours_i),
    .b_minutes_i (b_minutes_i),
    .b_seconds_i (b_seconds_i),
    .factor_i    (factor_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .r_days_o    (r_days_o),
    .r_hours_o   (r_hours_o),
    .r_minutes_o (r_minutes_o),
    .r_seconds_o (r_seconds_o),
    .a_less_b_o  (a_less_b_o),
    .a_equal_b_o (a_equal_b_o),
    .overflow_o  (overflow_o)
  );

  // free-running clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // seconds inside one operand, raw fields at full weight
  function automatic logic [63:0] day_seconds(dur_t d);
    return 64'(d.hours) * SECS_PER_HOUR + 64'(d.minutes) * SECS_PER_MIN + 64'(d.seconds);
  endfunction

  // fold whole days plus loose seconds into a normalised duration, saturating on overflow
  function automatic dur_res_t normalise(logic [63:0] days_in, logic [63:0] secs_in);
    dur_res_t   res;
    logic [63:0] days;
    logic [63:0] secs;
    res  = '0;
    days = days_in + secs_in / SECS_PER_DAY;
    secs = secs_in % SECS_PER_DAY;
    if (days > 64'(DAY_MAX)) begin
      res.r        = '{DAY_MAX, MAX_HOUR, MAX_MIN, MAX_SEC};
      res.overflow = 1'b1;
    end else begin
      res.r.days    = DAY_W'(days);
      res.r.hours   = HOUR_W'(secs / SECS_PER_HOUR);
      res.r.minutes = MIN_W'((secs / SECS_PER_MIN) % SECS_PER_MIN);
      res.r.seconds = SEC_W'(secs % SECS_PER_MIN);
    end
    return res;
  endfunction

  // expected result of one input beat
  function automatic dur_res_t duration_result(dur_op_t op);
    dur_res_t    res;
    logic [63:0] a_secs, b_secs, a_total, b_total, fac;
    res     = '0;
    a_secs  = day_seconds(op.a);
    b_secs  = day_seconds(op.b);
    a_total = 64'(op.a.days) * SECS_PER_DAY + a_secs;
    b_total = 64'(op.b.days) * SECS_PER_DAY + b_secs;
    fac     = 64'(op.factor);
    case (op.func)
      FN_ADD: begin
        res = normalise(64'(op.a.days) + 64'(op.b.days), a_secs + b_secs);
      end
      FN_SUB: begin
        // floored at zero when a does not exceed b
        if (a_total > b_total) res = normalise('0, a_total - b_total);
      end
      FN_SCALE: begin
        // zero or negative factor gives zero
        if (!op.factor[FACT_W-1] && op.factor != '0)
          res = normalise(64'(op.a.days) * fac, a_secs * fac);
      end
      default: ;
    endcase
    // flags from the raw fields, lexicographic
    res.equal = (op.a == op.b);
    if (op.a.days != op.b.days) res.less = op.a.days < op.b.days;
    else if (op.a.hours != op.b.hours) res.less = op.a.hours < op.b.hours;
    else if (op.a.minutes != op.b.minutes) res.less = op.a.minutes < op.b.minutes;
    else res.less = op.a.seconds < op.b.seconds;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dur_t dur(int d, int h, int m, int s);
    return '{DAY_W'(d), HOUR_W'(h), MIN_W'(m), SEC_W'(s)};
  endfunction

  function automatic dur_op_t make_op(logic [1:0] fn, dur_t a, dur_t b,
                                      logic [FACT_W-1:0] fac);
    return '{fn, a, b, fac};
  endfunction

  // drive one beat, hold it until taken, then pace the next one
  task automatic send_op(dur_op_t op);
    in_valid_i  = 1'b1;
    func_i      = op.func;
    a_days_i    = op.a.days;
    a_hours_i   = op.a.hours;
    a_minutes_i = op.a.minutes;
    a_seconds_i = op.a.seconds;
    b_days_i    = op.b.days;
    b_hours_i   = op.b.hours;
    b_minutes_i = op.b.minutes;
    b_seconds_i = op.b.seconds;
    factor_i    = op.factor;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(duration_result(op));
    @(negedge clk_i);
    // bursts of random length with random gaps, now and then a long unbroken run
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  function automatic logic [DAY_W-1:0] rand_days();
    case ($urandom_range(0, 9))
      0:          return '0;
      1, 2, 3, 4: return DAY_W'($urandom_range(0, 20));
      5, 6, 7:    return DAY_W'($urandom);
      default:    return DAY_MAX - DAY_W'($urandom_range(0, 3));
    endcase
  endfunction

  // mostly normalised operands, a few with raw out-of-range fields
  function automatic dur_t rand_duration();
    dur_t d;
    d.days = rand_days();
    if ($urandom_range(0, 9) == 0) begin
      d.hours   = HOUR_W'($urandom_range(0, 31));
      d.minutes = MIN_W'($urandom_range(0, 63));
      d.seconds = SEC_W'($urandom_range(0, 63));
    end else begin
      d.hours   = HOUR_W'($urandom_range(0, 23));
      d.minutes = MIN_W'($urandom_range(0, 59));
      d.seconds = SEC_W'($urandom_range(0, 59));
    end
    return d;
  endfunction

  function automatic logic [FACT_W-1:0] rand_factor();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FACT_W'(-int'($urandom_range(1, 32768)));
      2, 3:    return FACT_W'($urandom);
      default: return FACT_W'($urandom_range(1, 40));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_add();
    send_op(make_op(FN_ADD, dur(0, 0, 0, 0), dur(0, 0, 0, 0), '0));
    send_op(make_op(FN_ADD, dur(0, 23, 59, 59), dur(0, 0, 0, 1), '0));
    send_op(make_op(FN_ADD, dur(65535, 0, 0, 0), dur(0, 0, 0, 0), '0));
    send_op(make_op(FN_ADD, dur(65535, 23, 59, 59), dur(0, 0, 0, 1), '0));
    send_op(make_op(FN_ADD, dur(65535, 23, 59, 59), dur(65535, 23, 59, 59), '1));
  endtask

  task automatic test_subtract();
    send_op(make_op(FN_SUB, dur(5, 12, 30, 30), dur(2, 6, 15, 10), '0));
    send_op(make_op(FN_SUB, dur(1, 0, 0, 0), dur(0, 0, 0, 1), '0));
    send_op(make_op(FN_SUB, dur(7, 7, 7, 7), dur(7, 7, 7, 7), '0));
    send_op(make_op(FN_SUB, dur(0, 0, 0, 0), dur(65535, 23, 59, 59), '0));
  endtask

  task automatic test_scale();
    send_op(make_op(FN_SCALE, dur(3, 4, 5, 6), dur(0, 0, 0, 0), '0));
    send_op(make_op(FN_SCALE, dur(3, 4, 5, 6), dur(0, 0, 0, 0), -16'sd1));
    send_op(make_op(FN_SCALE, dur(3, 4, 5, 6), dur(0, 0, 0, 0), 16'h8000));
    send_op(make_op(FN_SCALE, dur(65535, 23, 59, 59), dur(0, 0, 0, 0), 16'sd1));
    send_op(make_op(FN_SCALE, dur(0, 12, 0, 0), dur(0, 0, 0, 0), 16'sd2));
    send_op(make_op(FN_SCALE, dur(0, 0, 0, 1), dur(0, 0, 0, 0), 16'sd32767));
    send_op(make_op(FN_SCALE, dur(2, 23, 59, 59), dur(0, 0, 0, 0), 16'sd32767));
  endtask

  // raw out-of-range fields, compare flags on raw values, unused function code
  task automatic test_special_cases();
    send_op(make_op(FN_ADD, dur(0, 31, 63, 63), dur(0, 31, 63, 63), '0));
    send_op(make_op(FN_SUB, dur(0, 25, 0, 0), dur(1, 0, 0, 0), '0));
    send_op(make_op(FN_SUB, dur(0, 24, 0, 0), dur(1, 0, 0, 0), '0));
    send_op(make_op(FN_SCALE, dur(0, 31, 63, 63), dur(0, 1, 0, 0), 16'sd3));
    send_op(make_op(FN_UNUSED, dur(9, 9, 9, 9), dur(9, 9, 9, 9), '1));
    send_op(make_op(FN_UNUSED, dur(1, 2, 3, 4), dur(1, 2, 3, 5), 16'sd5));
  endtask

  task automatic test_random_mix();
    dur_op_t op;
    int      pick;
    for (int i = 0; i < RAND_BEATS; i++) begin
      pick      = $urandom_range(0, 19);
      op.func   = (pick < 6) ? FN_ADD : (pick < 12) ? FN_SUB : (pick < 19) ? FN_SCALE : FN_UNUSED;
      op.a      = rand_duration();
      op.b      = rand_duration();
      op.factor = rand_factor();
      // near-equal operands so the finer compare fields and the zero floor get exercised
      if (op.func == FN_SUB && $urandom_range(0, 9) < 4) op.b.days = op.a.days;
      if ($urandom_range(0, 19) == 0) op.b = op.a;
      send_op(op);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // compare each accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual days %0d", $time, r_days_o);
        error_count++;
      end else begin
        oldest_res = expected_q.pop_front();
        check_field("r_days", oldest_res.r.days, r_days_o);
        check_field("r_hours", oldest_res.r.hours, r_hours_o);
        check_field("r_minutes", oldest_res.r.minutes, r_minutes_o);
        check_field("r_seconds", oldest_res.r.seconds, r_seconds_o);
        check_field("a_less_b", oldest_res.less, a_less_b_o);
        check_field("a_equal_b", oldest_res.equal, a_equal_b_o);
        check_field("overflow", oldest_res.overflow, overflow_o);
      end
    end
  end

  // output stall: a new pattern is drawn at random whenever rx_tick wraps
  always @(negedge clk_i) begin
    if (rx_tick == '0) rx_mode = $urandom_range(0, 3);
    rx_tick = rx_tick + 1'b1;
    case (rx_mode)
      0:       out_stall_i = 1'b0;
      1:       out_stall_i = ($urandom_range(0, 3) == 0);
      2:       out_stall_i = (rx_tick % 7) < 3;
      default: out_stall_i = (rx_tick[3:0] < 4'd10);
    endcase
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    func_i      = FN_ADD;
    a_days_i    = '0;
    a_hours_i   = '0;
    a_minutes_i = '0;
    a_seconds_i = '0;
    b_days_i    = '0;
    b_hours_i   = '0;
    b_minutes_i = '0;
    b_seconds_i = '0;
    factor_i    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_add();
    test_subtract();
    test_scale();
    test_special_cases();
    test_random_mix();
    in_valid_i = 1'b0;

    // drain, then allow for anything stray to appear
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
